// ===== rtl/core/xalu_pkg.sv =====
// Shared types and constants for the x86 integer ALU.
`timescale 1ns / 1ps
package xalu_pkg;

    localparam logic [3:0] KIND_ADD  = 4'd0;
    localparam logic [3:0] KIND_ADC  = 4'd1;
    localparam logic [3:0] KIND_SUB  = 4'd2;
    localparam logic [3:0] KIND_SBB  = 4'd3;
    localparam logic [3:0] KIND_AND  = 4'd4;
    localparam logic [3:0] KIND_OR   = 4'd5;
    localparam logic [3:0] KIND_XOR  = 4'd6;
    localparam logic [3:0] KIND_SHL  = 4'd7;
    localparam logic [3:0] KIND_SHR  = 4'd8;
    localparam logic [3:0] KIND_SAR  = 4'd9;
    localparam logic [3:0] KIND_MUL  = 4'd10;
    localparam logic [3:0] KIND_IMUL = 4'd11;
    localparam logic [3:0] KIND_DIV  = 4'd12;
    localparam logic [3:0] KIND_IDIV = 4'd13;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;

    localparam logic [5:0] DIV_STEP_LAST = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL,
        ST_DIV,
        ST_DIVFIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic mul_cap;
        logic mul_fin;
        logic div_start;
        logic div_step;
        logic div_fin;
    } cmd_t;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_zero;
        logic div_last;
    } stat_t;

endpackage

// ===== rtl/core/xalu_ctrl.sv =====
// Sequencing state machine for the x86 integer ALU.
`timescale 1ns / 1ps
module xalu_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  xalu_pkg::stat_t stat,
    output xalu_pkg::cmd_t  cmd
);

    xalu_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= xalu_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            xalu_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = xalu_pkg::ST_DISPATCH;
                end
            end
            xalu_pkg::ST_DISPATCH: begin
                if (stat.is_mul) begin
                    cmd.mul_cap = 1'b1;
                    state_next  = xalu_pkg::ST_MUL;
                end else if (stat.is_div && !stat.div_zero) begin
                    cmd.div_start = 1'b1;
                    state_next    = xalu_pkg::ST_DIV;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = xalu_pkg::ST_OUT;
                end
            end
            xalu_pkg::ST_MUL: begin
                cmd.mul_fin = 1'b1;
                state_next  = xalu_pkg::ST_OUT;
            end
            xalu_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = xalu_pkg::ST_DIVFIN;
                end
            end
            xalu_pkg::ST_DIVFIN: begin
                cmd.div_fin = 1'b1;
                state_next  = xalu_pkg::ST_OUT;
            end
            xalu_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = xalu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = xalu_pkg::ST_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output sides open together");

    a_cmd_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command");

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == xalu_pkg::ST_DIV && stat.div_last)
        |=> state_reg == xalu_pkg::ST_DIVFIN)
        else $error("divide did not finish after last step");

    a_load_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == xalu_pkg::ST_DISPATCH)
        else $error("accepted beat not dispatched");

endmodule

// ===== rtl/core/xalu_dp.sv =====
// Operand registers, ALU, multiplier, shift-subtract divider and flags.
`timescale 1ns / 1ps
module xalu_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  xalu_pkg::cmd_t  cmd,
    output xalu_pkg::stat_t stat,
    input  logic [3:0]      in_kind,
    input  logic [31:0]     in_src,
    input  logic [63:0]     in_dest,
    input  logic [1:0]      in_size,
    output logic [63:0]     result,
    output logic [31:0]     remainder,
    output logic            carry_out,
    output logic            parity_out,
    output logic            zero_out,
    output logic            sign_out,
    output logic            overflow_out,
    output logic            divide_error
);

    logic [3:0]  kind_reg;
    logic [31:0] src_reg;
    logic [63:0] dest_reg;
    logic [1:0]  size_reg;

    logic cf_reg, pf_reg, zf_reg, sf_reg, of_reg;
    logic cf_next, pf_next, zf_next, sf_next, of_next;

    logic [63:0] result_reg;
    logic [31:0] rem_reg_out;
    logic        derr_reg;

    logic [63:0] prod_reg;
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic        negq_reg, negr_reg;
    logic [5:0]  cnt_reg;

    logic [31:0] m32;
    logic [63:0] m64;
    logic [31:0] a, b;
    logic [63:0] a_s, b_s;
    logic [4:0]  n;

    function automatic logic msb_at(input logic [31:0] v, input logic [1:0] ds);
        logic r;
        case (ds)
            xalu_pkg::SIZE_8:  r = v[7];
            xalu_pkg::SIZE_16: r = v[15];
            default:           r = v[31];
        endcase
        return r;
    endfunction

    always_comb begin
        case (size_reg)
            xalu_pkg::SIZE_8: begin
                m32 = 32'h0000_00FF;
                m64 = 64'h0000_0000_0000_FFFF;
            end
            xalu_pkg::SIZE_16: begin
                m32 = 32'h0000_FFFF;
                m64 = 64'h0000_0000_FFFF_FFFF;
            end
            default: begin
                m32 = 32'hFFFF_FFFF;
                m64 = 64'hFFFF_FFFF_FFFF_FFFF;
            end
        endcase
    end

    assign a = dest_reg[31:0] & m32;
    assign b = src_reg & m32;
    assign n = src_reg[4:0];

    always_comb begin
        case (size_reg)
            xalu_pkg::SIZE_8: begin
                a_s = {{56{a[7]}}, a[7:0]};
                b_s = {{56{b[7]}}, b[7:0]};
            end
            xalu_pkg::SIZE_16: begin
                a_s = {{48{a[15]}}, a[15:0]};
                b_s = {{48{b[15]}}, b[15:0]};
            end
            default: begin
                a_s = {{32{a[31]}}, a};
                b_s = {{32{b[31]}}, b};
            end
        endcase
    end

    assign stat.is_mul   = (kind_reg == xalu_pkg::KIND_MUL) || (kind_reg == xalu_pkg::KIND_IMUL);
    assign stat.is_div   = (kind_reg == xalu_pkg::KIND_DIV) || (kind_reg == xalu_pkg::KIND_IDIV);
    assign stat.div_zero = (b == 32'd0);
    assign stat.div_last = (cnt_reg == xalu_pkg::DIV_STEP_LAST);

    // Combinational ALU and shifter
    logic        cin;
    logic [32:0] sum33, dif33;
    logic [63:0] shl64, sar64;
    logic [31:0] res_x;
    logic        derr_x;
    logic        addc, subc, shlc;

    assign cin   = cf_reg & ((kind_reg == xalu_pkg::KIND_ADC) || (kind_reg == xalu_pkg::KIND_SBB));
    assign sum33 = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    assign dif33 = {1'b0, a} - {1'b0, b} - {32'd0, cin};
    assign shl64 = {32'd0, a} << n;
    assign sar64 = a_s >>> n;

    always_comb begin
        case (size_reg)
            xalu_pkg::SIZE_8: begin
                addc = sum33[8];
                shlc = shl64[8];
            end
            xalu_pkg::SIZE_16: begin
                addc = sum33[16];
                shlc = shl64[16];
            end
            default: begin
                addc = sum33[32];
                shlc = shl64[32];
            end
        endcase
    end
    assign subc = dif33[32];

    always_comb begin
        res_x   = 32'd0;
        derr_x  = 1'b0;
        cf_next = cf_reg;
        pf_next = pf_reg;
        zf_next = zf_reg;
        sf_next = sf_reg;
        of_next = of_reg;
        case (kind_reg)
            xalu_pkg::KIND_ADD, xalu_pkg::KIND_ADC: begin
                res_x   = sum33[31:0] & m32;
                cf_next = addc;
                of_next = msb_at(~(a ^ b) & (a ^ res_x), size_reg);
            end
            xalu_pkg::KIND_SUB, xalu_pkg::KIND_SBB: begin
                res_x   = dif33[31:0] & m32;
                cf_next = subc;
                of_next = msb_at((a ^ b) & (a ^ res_x), size_reg);
            end
            xalu_pkg::KIND_AND, xalu_pkg::KIND_OR, xalu_pkg::KIND_XOR: begin
                res_x   = (kind_reg == xalu_pkg::KIND_AND) ? (a & b) :
                          (kind_reg == xalu_pkg::KIND_OR)  ? (a | b) : (a ^ b);
                cf_next = 1'b0;
                of_next = 1'b0;
            end
            xalu_pkg::KIND_SHL: begin
                res_x = a;
                if (n != 5'd0) begin
                    res_x   = shl64[31:0] & m32;
                    cf_next = shlc;
                    if (n == 5'd1) begin
                        of_next = msb_at(res_x, size_reg) ^ shlc;
                    end
                end
            end
            xalu_pkg::KIND_SHR: begin
                res_x = a;
                if (n != 5'd0) begin
                    res_x   = a >> n;
                    cf_next = a[n - 5'd1];
                    if (n == 5'd1) begin
                        of_next = msb_at(a, size_reg);
                    end
                end
            end
            xalu_pkg::KIND_SAR: begin
                res_x = a;
                if (n != 5'd0) begin
                    res_x   = sar64[31:0] & m32;
                    cf_next = a_s[n - 5'd1];
                    if (n == 5'd1) begin
                        of_next = 1'b0;
                    end
                end
            end
            xalu_pkg::KIND_DIV, xalu_pkg::KIND_IDIV: begin
                derr_x = 1'b1;
            end
            default: begin
                res_x = 32'd0;
            end
        endcase
    end

    logic upd_pzs;
    assign upd_pzs = (kind_reg <= xalu_pkg::KIND_XOR) ||
                     (((kind_reg == xalu_pkg::KIND_SHL) || (kind_reg == xalu_pkg::KIND_SHR) ||
                       (kind_reg == xalu_pkg::KIND_SAR)) && (n != 5'd0));

    // Multiplier, operands sign- or zero-extended to 33 bits
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod66;
    logic [63:0]        prod_m;
    logic               mul_hi;

    assign ma     = (kind_reg == xalu_pkg::KIND_IMUL) ? $signed(a_s[32:0]) : $signed({1'b0, a});
    assign mb     = (kind_reg == xalu_pkg::KIND_IMUL) ? $signed(b_s[32:0]) : $signed({1'b0, b});
    assign prod66 = ma * mb;
    assign prod_m = prod_reg & m64;

    always_comb begin
        case (size_reg)
            xalu_pkg::SIZE_8:  mul_hi = |prod_m[15:8];
            xalu_pkg::SIZE_16: mul_hi = |prod_m[31:16];
            default:           mul_hi = |prod_m[63:32];
        endcase
    end

    // Divider setup and one restoring step a cycle
    logic [63:0] dd_s, dd_mag;
    logic [31:0] dv_s, dv_mag;
    logic        is_idiv, nd, nv;
    logic [32:0] trial, trial_sub;
    logic        ge;
    logic [63:0] q_fin;
    logic [31:0] r_fin;

    assign is_idiv = (kind_reg == xalu_pkg::KIND_IDIV);

    always_comb begin
        case (size_reg)
            xalu_pkg::SIZE_8:  dd_s = {{48{dest_reg[15]}}, dest_reg[15:0]};
            xalu_pkg::SIZE_16: dd_s = {{32{dest_reg[31]}}, dest_reg[31:0]};
            default:           dd_s = dest_reg;
        endcase
    end

    assign dv_s   = b_s[31:0];
    assign nd     = is_idiv & dd_s[63];
    assign nv     = is_idiv & dv_s[31];
    assign dd_mag = !is_idiv ? (dest_reg & m64) : (nd ? (~dd_s + 64'd1) : dd_s);
    assign dv_mag = !is_idiv ? b : (nv ? (~dv_s + 32'd1) : dv_s);

    assign trial     = {rem_reg, quo_reg[63]};
    assign ge        = (trial >= {1'b0, dvs_reg});
    assign trial_sub = trial - {1'b0, dvs_reg};

    assign q_fin = negq_reg ? (~quo_reg + 64'd1) : quo_reg;
    assign r_fin = negr_reg ? (~rem_reg + 32'd1) : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cf_reg <= 1'b0;
            pf_reg <= 1'b0;
            zf_reg <= 1'b0;
            sf_reg <= 1'b0;
            of_reg <= 1'b0;
        end else if (cmd.exec) begin
            cf_reg <= cf_next;
            of_reg <= of_next;
            if (upd_pzs) begin
                pf_reg <= ~^res_x[7:0];
                zf_reg <= (res_x == 32'd0);
                sf_reg <= msb_at(res_x, size_reg);
            end
        end else if (cmd.mul_fin && (kind_reg == xalu_pkg::KIND_MUL)) begin
            cf_reg <= mul_hi;
            of_reg <= mul_hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;
            src_reg  <= in_src;
            dest_reg <= in_dest;
            size_reg <= in_size;
        end
        if (cmd.exec) begin
            result_reg  <= {32'd0, res_x};
            rem_reg_out <= 32'd0;
            derr_reg    <= derr_x;
        end
        if (cmd.mul_cap) begin
            prod_reg <= prod66[63:0];
        end
        if (cmd.mul_fin) begin
            result_reg  <= prod_m;
            rem_reg_out <= 32'd0;
            derr_reg    <= 1'b0;
        end
        if (cmd.div_start) begin
            quo_reg  <= dd_mag;
            rem_reg  <= 32'd0;
            dvs_reg  <= dv_mag;
            negq_reg <= nd ^ nv;
            negr_reg <= nd;
            cnt_reg  <= 6'd0;
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? trial_sub[31:0] : trial[31:0];
            quo_reg <= {quo_reg[62:0], ge};
            cnt_reg <= cnt_reg + 6'd1;
        end
        if (cmd.div_fin) begin
            result_reg  <= {32'd0, q_fin[31:0] & m32};
            rem_reg_out <= r_fin & m32;
            derr_reg    <= 1'b0;
        end
    end

    assign result       = result_reg;
    assign remainder    = rem_reg_out;
    assign divide_error = derr_reg;
    assign carry_out    = cf_reg;
    assign parity_out   = pf_reg;
    assign zero_out     = zf_reg;
    assign sign_out     = sf_reg;
    assign overflow_out = of_reg;

endmodule

// ===== rtl/core/x86_integer_alu_with_flags.sv =====
// Top level of the x86 integer ALU with kept flags.
//
// One beat on the s_ channel carries one operation (kind and size in tuser,
// operands in tdata); one beat on the m_ channel returns its result, the
// flags as they stand afterwards, and a divide-error bit in tuser.
// The block works on one beat at a time: s_tready is high only while it is
// idle, and drops from the accept until the result beat is taken.
// Path from accept to m_tvalid: the controller goes through DISPATCH and then OUT
// for add, adc, sub, sbb, logic operations, shifts, divides by zero and unused
// kinds; through DISPATCH, MUL and OUT for mul and imul (one registered 33x33
// multiplier); through DISPATCH, DIV and DIVFIN to OUT for div and idiv, the
// restoring divider in DIV retiring one quotient bit a cycle over a 64-bit dividend.
// A result beat holds steady while m_tready is low, and no new beat is
// accepted until it goes out.
// Synchronous active-low reset clears the flags to zero and returns the
// controller to idle; no beat is in flight after reset.
`timescale 1ns / 1ps
module x86_integer_alu_with_flags (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,  // src[31:0], dest[95:32]
    input  logic [5:0]   s_tuser,  // kind[3:0], op_size[5:4]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,  // result[63:0], remainder[95:64], carry_out[96],
                                   // parity_out[97], zero_out[98], sign_out[99],
                                   // overflow_out[100], zero pad[103:101]
    output logic         m_tuser   // divide_error
);

    xalu_pkg::cmd_t  cmd;
    xalu_pkg::stat_t stat;

    logic [63:0] result;
    logic [31:0] remainder;
    logic        carry_out, parity_out, zero_out, sign_out, overflow_out, divide_error;

    xalu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    xalu_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_kind      (s_tuser[3:0]),
        .in_src       (s_tdata[31:0]),
        .in_dest      (s_tdata[95:32]),
        .in_size      (s_tuser[5:4]),
        .result       (result),
        .remainder    (remainder),
        .carry_out    (carry_out),
        .parity_out   (parity_out),
        .zero_out     (zero_out),
        .sign_out     (sign_out),
        .overflow_out (overflow_out),
        .divide_error (divide_error)
    );

    assign m_tdata = {3'b000, overflow_out, sign_out, zero_out, parity_out, carry_out,
                      remainder, result};
    assign m_tuser = divide_error;

endmodule
